@@ hdl/bitplane_palette_pixel_expander_top_macros.svh @@
// assertion helpers, clocked on aclk and quiet during reset
`ifndef BITPLANE_PALETTE_PIXEL_EXPANDER_TOP_MACROS_SVH
`define BITPLANE_PALETTE_PIXEL_EXPANDER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BPPE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bppe assertion failed");

// next-cycle implication
`define BPPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bppe assertion failed");

`else

`define BPPE_ASSERT_SAME(lbl, ante, cons)
`define BPPE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/bppe_pkg.sv @@
`default_nettype none

package bppe_pkg;

    // palette geometry
    localparam int PALETTE_ENTRIES = 16;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int COLOUR_W        = 24;
    localparam int IDX_W           = 4;

    // expansion
    localparam int PIXELS_PER_BYTE = 8;
    localparam int CNT_W           = $clog2(PIXELS_PER_BYTE);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PIXELS_PER_BYTE - 1);

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // apb
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic {
        FUNC_PALETTE = 1'b0,
        FUNC_PLANE   = 1'b1
    } func_t;

    // register word index (paddr[2])
    typedef enum logic {
        REG_DISPLAY_ENABLE = 1'b0,
        REG_PLANE_MODE     = 1'b1
    } reg_idx_t;

    // input payload, last member in the lowest bits
    typedef struct packed {
        logic [3:0]       pad;
        logic [7:0]       plane_three;
        logic [7:0]       plane_two;
        logic [7:0]       plane_one;
        logic [7:0]       plane_zero;
        logic [7:0]       in_blue;
        logic [7:0]       in_green;
        logic [7:0]       in_red;
        logic [IDX_W-1:0] palette_index;
    } s_data_t;

    // result payload
    typedef struct packed {
        logic [3:0]       pad;
        logic [IDX_W-1:0] colour_index;
        logic [7:0]       out_blue;
        logic [7:0]       out_green;
        logic [7:0]       out_red;
    } m_data_t;

    // one pixel moving through the read stage
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             hit;
        logic             last;
    } pix_ctl_t;

endpackage

`default_nettype wire

@@ hdl/bppe_ram.sv @@
`default_nettype none

module bppe_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // read-first: a read and a write in the same cycle returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/bitplane_palette_pixel_expander_top.sv @@
// Planar-to-chunky expander with a 16-entry 24-bit RGB palette. A request with
// tuser = 0 stores one colour at palette_index and gives no result; a request
// with tuser = 1 carries one byte of each bitplane and, while the display is
// enabled, gives eight pixels, bit 0 of the bytes first, the eighth marked by
// m_tlast. Plane 0 supplies index bit 0; in two-plane mode planes 2 and 3 read
// as zero. Each pixel carries its colour index and the palette colour at it.
// While the read stage is free the expander issues one palette read per cycle
// through the single read port of the palette memory; the stream runs at one
// pixel per cycle while m_tready holds. A palette write is taken in the cycle
// the previous plane request issues its last read. Each pixel passes the plane
// registers, the read stage and the output register. Palette entries read as
// black until written (per-entry valid flags, no clearing pass after reset).
// Registers: 0x0 display_enable (reset 1), 0x4 plane_mode (reset 0, 1 = four
// planes). Change them only while no request is in flight.
`default_nettype none

`include "bitplane_palette_pixel_expander_top_macros.svh"

module bitplane_palette_pixel_expander_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // palette_index[3:0], in_red[11:4], in_green[19:12], in_blue[27:20],
    // plane_zero[35:28], plane_one[43:36], plane_two[51:44],
    // plane_three[59:52], zero[63:60]
    input  wire logic [bppe_pkg::S_TDATA_W-1:0]  s_tdata,
    // func[0]
    input  wire logic                            s_tuser,
    // pixel stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], colour_index[27:24],
    // zero[31:28]
    output logic      [bppe_pkg::M_TDATA_W-1:0]  m_tdata,
    // last_pixel
    output logic                                 m_tlast,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bppe_pkg::APB_AW-1:0]     paddr,
    input  wire logic [bppe_pkg::APB_DW-1:0]     pwdata,
    output logic      [bppe_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);

    // ---------------------------------------------------------------
    // register file
    // ---------------------------------------------------------------
    logic                 disp_en_reg, disp_en_next;
    logic                 mode_reg, mode_next;
    logic                 cfg_wr;
    bppe_pkg::reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bppe_pkg::reg_idx_t'(paddr[2]);

    always_comb begin
        disp_en_next = disp_en_reg;
        mode_next    = mode_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                bppe_pkg::REG_DISPLAY_ENABLE: disp_en_next = pwdata[0];
                bppe_pkg::REG_PLANE_MODE:     mode_next    = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bppe_pkg::REG_DISPLAY_ENABLE: prdata = {{(bppe_pkg::APB_DW-1){1'b0}}, disp_en_reg};
            bppe_pkg::REG_PLANE_MODE:     prdata = {{(bppe_pkg::APB_DW-1){1'b0}}, mode_reg};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_en_reg <= 1'b1;
            mode_reg    <= 1'b0;
        end else begin
            disp_en_reg <= disp_en_next;
            mode_reg    <= mode_next;
        end
    end

    // ---------------------------------------------------------------
    // request decode
    // ---------------------------------------------------------------
    bppe_pkg::s_data_t  s_data;
    bppe_pkg::func_t    s_func;
    logic               s_acc;
    logic               pal_wr;
    logic               plane_load;
    logic               wr_in_range;
    logic [bppe_pkg::PAL_AW-1:0] wr_addr;

    assign s_data     = bppe_pkg::s_data_t'(s_tdata);
    assign s_func     = bppe_pkg::func_t'(s_tuser);
    assign s_acc      = s_tvalid && s_tready;
    // writes beyond the palette are dropped
    assign wr_in_range = 32'(s_data.palette_index) < bppe_pkg::PALETTE_ENTRIES;
    assign wr_addr    = s_data.palette_index[bppe_pkg::PAL_AW-1:0];
    assign pal_wr     = s_acc && (s_func == bppe_pkg::FUNC_PALETTE) && wr_in_range;
    // display off: plane request is consumed with no pixels
    assign plane_load = s_acc && (s_func == bppe_pkg::FUNC_PLANE) && disp_en_reg;

    // ---------------------------------------------------------------
    // pipeline handshake: expander -> read stage -> output register
    // ---------------------------------------------------------------
    logic gen_vld_reg, gen_vld_next;
    logic rd_vld_reg, rd_vld_next;
    logic out_vld_reg, out_vld_next;
    logic out_free, rd_free;
    logic gen_issue, gen_last_issue;

    logic [7:0] p0_reg, p0_next;
    logic [7:0] p1_reg, p1_next;
    logic [7:0] p2_reg, p2_next;
    logic [7:0] p3_reg, p3_next;
    logic [bppe_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign out_free       = !out_vld_reg || m_tready;
    assign rd_free        = !rd_vld_reg || out_free;
    assign gen_issue      = gen_vld_reg && rd_free;
    assign gen_last_issue = gen_issue && (cnt_reg == bppe_pkg::LAST_CNT);

    // a new request (either kind) once the last read of the current one goes out;
    // a palette write in that same cycle lands after the read (read-first memory)
    assign s_tready = !gen_vld_reg || gen_last_issue;

    // ---------------------------------------------------------------
    // expander: shift the plane bytes one bit per issued pixel
    // ---------------------------------------------------------------
    always_comb begin
        gen_vld_next = gen_vld_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        p3_next      = p3_reg;
        cnt_next     = cnt_reg;
        if (gen_issue) begin
            p0_next  = p0_reg >> 1;
            p1_next  = p1_reg >> 1;
            p2_next  = p2_reg >> 1;
            p3_next  = p3_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (gen_last_issue) begin
                gen_vld_next = 1'b0;
            end
        end
        if (plane_load) begin
            gen_vld_next = 1'b1;
            p0_next      = s_data.plane_zero;
            p1_next      = s_data.plane_one;
            // two-plane mode: upper planes read as zero
            p2_next      = mode_reg ? s_data.plane_two   : 8'h00;
            p3_next      = mode_reg ? s_data.plane_three : 8'h00;
            cnt_next     = '0;
        end
    end

    // ---------------------------------------------------------------
    // palette: valid flag per entry, storage in the generic ram
    // ---------------------------------------------------------------
    logic [bppe_pkg::PALETTE_ENTRIES-1:0] pal_vld_reg, pal_vld_next;
    logic [bppe_pkg::IDX_W-1:0]           rd_idx;
    logic [bppe_pkg::PAL_AW-1:0]          rd_addr;
    logic                                 rd_in_range;
    logic [bppe_pkg::COLOUR_W-1:0]        ram_rdata;
    logic [bppe_pkg::COLOUR_W-1:0]        wr_colour;

    assign rd_idx      = {p3_reg[0], p2_reg[0], p1_reg[0], p0_reg[0]};
    assign rd_addr     = rd_idx[bppe_pkg::PAL_AW-1:0];
    assign rd_in_range = 32'(rd_idx) < bppe_pkg::PALETTE_ENTRIES;
    assign wr_colour   = {s_data.in_red, s_data.in_green, s_data.in_blue};

    always_comb begin
        pal_vld_next = pal_vld_reg;
        if (pal_wr) begin
            pal_vld_next[wr_addr] = 1'b1;
        end
    end

    bppe_ram #(
        .DATA_W (bppe_pkg::COLOUR_W),
        .DEPTH  (bppe_pkg::PALETTE_ENTRIES),
        .ADDR_W (bppe_pkg::PAL_AW)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_wr),
        .waddr (wr_addr),
        .wdata (wr_colour),
        .re    (gen_issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // read stage: control travels beside the ram read
    // ---------------------------------------------------------------
    bppe_pkg::pix_ctl_t rd_ctl_reg, rd_ctl_next;

    always_comb begin
        rd_vld_next = rd_vld_reg;
        rd_ctl_next = rd_ctl_reg;
        if (rd_free) begin
            rd_vld_next = gen_issue;
        end
        if (gen_issue) begin
            // unwritten or out-of-range entries read black
            rd_ctl_next.idx  = rd_idx;
            rd_ctl_next.hit  = rd_in_range && pal_vld_reg[rd_addr];
            rd_ctl_next.last = (cnt_reg == bppe_pkg::LAST_CNT);
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    bppe_pkg::m_data_t out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic [bppe_pkg::COLOUR_W-1:0] px_colour;

    assign px_colour = rd_ctl_reg.hit ? ram_rdata : '0;

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        if (out_free) begin
            out_vld_next = rd_vld_reg;
        end
        if (rd_vld_reg && out_free) begin
            out_data_next.pad          = '0;
            out_data_next.colour_index = rd_ctl_reg.idx;
            out_data_next.out_red      = px_colour[23:16];
            out_data_next.out_green    = px_colour[15:8];
            out_data_next.out_blue     = px_colour[7:0];
            out_last_next              = rd_ctl_reg.last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pal_vld_reg <= '0;
            cnt_reg     <= '0;
        end else begin
            gen_vld_reg <= gen_vld_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
            pal_vld_reg <= pal_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p3_reg       <= p3_next;
        rd_ctl_reg   <= rd_ctl_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a held read stage must keep the ram output frozen
    `BPPE_ASSERT_NEXT(a_rd_hold, rd_vld_reg && !out_free, rd_vld_reg && $stable(ram_rdata))
    // no read is issued into an occupied, stalled read stage
    `BPPE_ASSERT_SAME(a_no_overrun, gen_issue, rd_free)
    // the eighth read of a request is the one marked last
    `BPPE_ASSERT_NEXT(a_last_mark, gen_last_issue, rd_vld_reg && rd_ctl_reg.last)
    // plane request with the display off leaves the expander empty
    `BPPE_ASSERT_NEXT(a_disp_off, s_acc && s_tuser && !disp_en_reg && !gen_vld_reg, !gen_vld_reg)

endmodule

`default_nettype wire
